// ----- sv/sacm_pkg.sv -----
// Package: shared types, constants and helpers for the set-associative cache model.
`default_nettype none
package sacm_pkg;

  localparam int unsigned WaysDefault       = 4;
  localparam int unsigned SetsDefault       = 64;
  localparam int unsigned BlockBytesDefault = 32;
  localparam int unsigned AgeWidthDefault   = 16;

  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned WayOutWidth = 2;
  localparam int unsigned PolicyWidth = 2;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [15:0] LfsrReset = 16'hACE1;

  // Replacement policy codes
  typedef enum logic [PolicyWidth-1:0] {
    POL_ROUND_ROBIN = 2'd0,
    POL_RANDOM      = 2'd1,
    POL_LRU         = 2'd2,
    POL_RESERVED    = 2'd3
  } policy_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_POLICY = 1'b0,
    CFG_NWA    = 1'b1
  } cfg_idx_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the request and start the set read
    logic update;   // evaluate the set and write it back
  } dp_cmd_t;

  // Advance the 16-bit Fibonacci LFSR (taps 16,14,13,11)
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[15:1]};
  endfunction

endpackage
`default_nettype wire

// ----- sv/sacm_ctrl.sv -----
// Controller: sequences read, update and result delivery for one request.
`default_nettype none
module sacm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sacm_pkg::dp_cmd_t      cmd_o
);

  sacm_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.update  = 1'b0;
    case (state_q)
      sacm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_d       = sacm_pkg::ST_READ;
        end
      end
      sacm_pkg::ST_READ: begin
        state_d = sacm_pkg::ST_UPDATE;
      end
      sacm_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sacm_pkg::ST_OUT;
      end
      sacm_pkg::ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd_o.capture = 1'b1;
            state_d       = sacm_pkg::ST_READ;
          end else begin
            state_d = sacm_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sacm_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/sacm_dp.sv -----
// Datapath: set memories, hit/victim logic, counters and result registers.
`default_nettype none
module sacm_dp #(
  parameter int unsigned WAYS        = sacm_pkg::WaysDefault,
  parameter int unsigned SETS        = sacm_pkg::SetsDefault,
  parameter int unsigned BLOCK_BYTES = sacm_pkg::BlockBytesDefault,
  parameter int unsigned AGE_WIDTH   = sacm_pkg::AgeWidthDefault
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire sacm_pkg::dp_cmd_t                      cmd_i,
  input  wire logic                                   cfg_we_i,
  input  wire logic [sacm_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  wire logic [31:0]                            cfg_data_i,
  input  wire logic                                   operation_i,
  input  wire logic [sacm_pkg::AddrWidth-1:0]         address_i,
  output logic                                        hit_o,
  output logic                                        filled_o,
  output logic                                        evicted_o,
  output logic [sacm_pkg::WayOutWidth-1:0]            way_used_o,
  output logic [sacm_pkg::CountWidth-1:0]             hit_total_o,
  output logic [sacm_pkg::CountWidth-1:0]             miss_total_o,
  output logic [sacm_pkg::CountWidth-1:0]             evict_total_o,
  output logic [sacm_pkg::CountWidth-1:0]             access_total_o
);

  localparam int unsigned OffBits = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;
  localparam int unsigned SetBits = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int unsigned SetW    = (SETS > 1) ? SetBits : 1;
  localparam int unsigned TagW    = sacm_pkg::AddrWidth - OffBits - SetBits;
  localparam int unsigned WayW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CntW    = sacm_pkg::CountWidth;
  localparam logic [AGE_WIDTH-1:0] AgeMax = '1;

  // Reciprocal constants for the LFSR value modulo WAYS
  localparam int unsigned RndShift = 16 + WayW;
  localparam int unsigned RndMul   = ((1 << RndShift) + WAYS - 1) / WAYS;
  localparam int unsigned RndProdW = 16 + RndShift + 1;

  // Row layouts, one row per set
  typedef logic [WAYS-1:0][TagW-1:0]      tag_row_t;
  typedef logic [WAYS-1:0][AGE_WIDTH-1:0] age_row_t;

  // Captured request
  logic            op_q;
  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;

  // Configuration
  logic [sacm_pkg::PolicyWidth-1:0] policy_q;
  logic                             nwa_q;

  // Memories and read registers
  tag_row_t        tag_mem [SETS];
  age_row_t        age_mem [SETS];
  tag_row_t        tag_rd_q;
  age_row_t        age_rd_q;

  // Per-set flop state cleared at reset, and the LFSR seeded at reset
  logic [SETS-1:0][WAYS-1:0] valid_q;
  logic [SETS-1:0]           age_ok_q;  // age row has been written since reset
  logic [SETS-1:0][WayW-1:0] rr_q;
  logic [15:0]               lfsr_q;

  logic [CntW-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q, acc_cnt_q;

  // Split the incoming address
  logic [SetW-1:0] set_in;
  logic [TagW-1:0] tag_in;
  always_comb begin
    set_in = '0;
    if (SETS > 1) begin
      set_in = SetW'(address_i >> OffBits);
    end
    tag_in = TagW'(address_i >> (OffBits + SetBits));
  end

  // Latch request and read the set
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= operation_i;
      set_q    <= set_in;
      tag_q    <= tag_in;
      tag_rd_q <= tag_mem[set_in];
      age_rd_q <= age_mem[set_in];
    end
  end

  // Evaluate the set
  logic [WAYS-1:0]     vrow;
  age_row_t            ages;
  age_row_t            ages_new;
  tag_row_t            tags_new;
  logic                hit;
  logic [WayW-1:0]     hit_way;
  logic                has_empty;
  logic [WayW-1:0]     empty_way;
  logic                allocate;
  logic [WayW-1:0]     victim;
  logic [WayW-1:0]     lru_way;
  logic [AGE_WIDTH-1:0] lru_age;
  logic [15:0]         lfsr_step;
  logic [RndProdW-1:0] rnd_prod;
  logic [15:0]         rnd_quo;
  logic [15:0]         rnd_rem;
  logic [WayW-1:0]     way_sel;
  logic                do_fill, do_evict;

  always_comb begin
    vrow = valid_q[set_q];
    ages = age_ok_q[set_q] ? age_rd_q : '0;
    hit = 1'b0;
    hit_way = '0;
    has_empty = 1'b0;
    empty_way = '0;
    ages_new = ages;
    for (int w = 0; w < WAYS; w++) begin
      if (vrow[w]) begin
        if (ages[w] != AgeMax) ages_new[w] = ages[w] + 1'b1;
        if (tag_rd_q[w] == tag_q) begin
          ages_new[w] = '0;
          if (!hit) hit_way = WayW'(w);
          hit = 1'b1;
        end
      end else if (!has_empty) begin
        has_empty = 1'b1;
        empty_way = WayW'(w);
      end
    end
    // LRU over the aged values, way 0 taken as is
    lru_way = '0;
    lru_age = ages_new[0];
    for (int w = 1; w < WAYS; w++) begin
      if (vrow[w] && ages_new[w] > lru_age) begin
        lru_age = ages_new[w];
        lru_way = WayW'(w);
      end
    end
    // Reduce the stepped LFSR modulo WAYS by reciprocal multiplication
    lfsr_step = sacm_pkg::lfsr_next(lfsr_q);
    rnd_prod  = RndProdW'(lfsr_step) * RndProdW'(RndMul);
    rnd_quo   = 16'(rnd_prod >> RndShift);
    rnd_rem   = lfsr_step - 16'(32'(rnd_quo) * WAYS);
    case (policy_q)
      sacm_pkg::POL_RANDOM: victim = WayW'(rnd_rem);
      sacm_pkg::POL_LRU:    victim = lru_way;
      default:              victim = rr_q[set_q];
    endcase
    allocate = !hit && !(op_q && nwa_q);
    do_fill  = allocate && has_empty;
    do_evict = allocate && !has_empty;
    way_sel  = hit ? hit_way : (do_fill ? empty_way : (do_evict ? victim : '0));
    tags_new = tag_rd_q;
    if (do_fill || do_evict) begin
      tags_new[way_sel] = tag_q;
      ages_new[way_sel] = '0;
    end
  end

  // Write back the set
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      tag_mem[set_q] <= tags_new;
      age_mem[set_q] <= ages_new;
    end
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      age_ok_q    <= '0;
      rr_q        <= '0;
      lfsr_q      <= sacm_pkg::LfsrReset;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      acc_cnt_q   <= '0;
      policy_q    <= sacm_pkg::POL_ROUND_ROBIN;
      nwa_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sacm_pkg::CFG_POLICY: policy_q <= cfg_data_i[sacm_pkg::PolicyWidth-1:0];
          sacm_pkg::CFG_NWA:    nwa_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        age_ok_q[set_q] <= 1'b1;
        acc_cnt_q <= acc_cnt_q + 1'b1;
        if (hit) hit_cnt_q <= hit_cnt_q + 1'b1;
        else     miss_cnt_q <= miss_cnt_q + 1'b1;
        if (do_fill) valid_q[set_q][way_sel] <= 1'b1;
        if (do_evict) begin
          evict_cnt_q <= evict_cnt_q + 1'b1;
          if (policy_q == sacm_pkg::POL_RANDOM) begin
            lfsr_q <= lfsr_step;
          end else if (policy_q != sacm_pkg::POL_LRU) begin
            rr_q[set_q] <= (32'(victim) + 1 == WAYS) ? '0 : WayW'(victim + 1'b1);
          end
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      hit_o      <= hit;
      filled_o   <= do_fill;
      evicted_o  <= do_evict;
      way_used_o <= sacm_pkg::WayOutWidth'(32'(way_sel));
    end
  end

  assign hit_total_o    = hit_cnt_q;
  assign miss_total_o   = miss_cnt_q;
  assign evict_total_o  = evict_cnt_q;
  assign access_total_o = acc_cnt_q;

endmodule
`default_nettype wire

// ----- sv/set_associative_cache_model_core.sv -----
// Top level: tag-only set-associative cache model with configurable replacement.
//
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   cfg     | cfg_valid, cfg_ready, cfg_index, data | in
//   request | in_valid, in_ready, operation, address| in
//   result  | out_valid, out_ready, hit .. totals   | out
//
// Each request is captured at the accepting edge, where the set is read into
// registers; the READ state waits, then in the UPDATE state the set is
// evaluated and written back; results are held until taken.
// A new request is accepted in the same cycle the previous result leaves.
// Reset clears valid bits, ages, pointers and counters and seeds the LFSR at once; no
// clearing pass. Tags are undefined until written.
`default_nettype none
module set_associative_cache_model_core #(
  parameter int unsigned WAYS        = sacm_pkg::WaysDefault,
  parameter int unsigned SETS        = sacm_pkg::SetsDefault,
  parameter int unsigned BLOCK_BYTES = sacm_pkg::BlockBytesDefault,
  parameter int unsigned AGE_WIDTH   = sacm_pkg::AgeWidthDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sacm_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  wire logic [31:0]                         cfg_data_i,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                operation_i,
  input  wire logic [sacm_pkg::AddrWidth-1:0]      address_i,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     hit_o,
  output logic                                     filled_o,
  output logic                                     evicted_o,
  output logic [sacm_pkg::WayOutWidth-1:0]         way_used_o,
  output logic [sacm_pkg::CountWidth-1:0]          hit_total_o,
  output logic [sacm_pkg::CountWidth-1:0]          miss_total_o,
  output logic [sacm_pkg::CountWidth-1:0]          evict_total_o,
  output logic [sacm_pkg::CountWidth-1:0]          access_total_o
);

  sacm_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  sacm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (cmd)
  );

  sacm_dp #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .AGE_WIDTH   (AGE_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_valid),
    .cfg_idx_i      (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .hit_o          (hit_o),
    .filled_o       (filled_o),
    .evicted_o      (evicted_o),
    .way_used_o     (way_used_o),
    .hit_total_o    (hit_total_o),
    .miss_total_o   (miss_total_o),
    .evict_total_o  (evict_total_o),
    .access_total_o (access_total_o)
  );

endmodule
`default_nettype wire
